// ----- hw/rtl/signed_gcd_lcm_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the signed gcd/lcm unit
// Clocked on clk; checks are off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_GCD_LCM_UNIT_ASSERT_SVH
`define SIGNED_GCD_LCM_UNIT_ASSERT_SVH

// Condition holds at every edge.
`define SGLU_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define SGLU_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sglu_pkg.sv -----
// ----------------------------------------------------------------------------
// sglu_pkg
// Shared types and constants of the signed gcd/lcm unit.
// ----------------------------------------------------------------------------
package sglu_pkg;

  localparam int DATA_W = 64;
  localparam int STEP_W = $clog2(DATA_W);
  localparam int SUM_W  = DATA_W + 2;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  localparam logic KIND_GCD = 1'b0;
  localparam logic KIND_LCM = 1'b1;

  typedef enum logic [1:0] {
    ALU_GCD,
    ALU_DIV,
    ALU_MUL
  } alu_op_t;

  // working registers touched by the shared step unit
  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [STEP_W-1:0] k;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] acc;
    logic              ovf;
  } work_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              ovf;
  } res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

// ----- hw/rtl/sglu_alu.sv -----
// ----------------------------------------------------------------------------
// sglu_alu
// Shared step unit: one binary-gcd step, one restoring divide step or one
// shift-add multiply step per cycle, all on a single wide adder.
// ----------------------------------------------------------------------------
module sglu_alu (
  input  sglu_pkg::alu_op_t                op,
  input  sglu_pkg::work_t                  st,
  input  logic [sglu_pkg::DATA_W-1:0]      den,
  output sglu_pkg::work_t                  nx,
  output logic                             gcd_done,
  output logic [sglu_pkg::DATA_W-1:0]      gcd_val
);

  logic [sglu_pkg::SUM_W-1:0]  opa;
  logic [sglu_pkg::SUM_W-1:0]  opb;
  logic [sglu_pkg::SUM_W-1:0]  sum;
  logic                        cin;
  logic                        x_ge_y;
  logic [sglu_pkg::DATA_W-1:0] hi_v;
  logic [sglu_pkg::DATA_W-1:0] lo_v;
  logic [sglu_pkg::DATA_W:0]   rem_sh;
  logic                        ovf_n;

  // operand select and the shared adder
  always_comb begin
    x_ge_y = (st.x >= st.y);
    hi_v   = x_ge_y ? st.x : st.y;
    lo_v   = x_ge_y ? st.y : st.x;
    rem_sh = {st.rem, st.quo[sglu_pkg::DATA_W-1]};
    opa    = '0;
    opb    = '0;
    cin    = 1'b0;
    case (op)
      sglu_pkg::ALU_GCD: begin
        opa = {2'b00, hi_v};
        opb = ~{2'b00, lo_v};
        cin = 1'b1;
      end
      sglu_pkg::ALU_DIV: begin
        opa = {1'b0, rem_sh};
        opb = ~{2'b00, den};
        cin = 1'b1;
      end
      sglu_pkg::ALU_MUL: begin
        opa = {1'b0, st.acc, 1'b0};
        opb = st.quo[sglu_pkg::DATA_W-1] ? {2'b00, den} : '0;
        cin = 1'b0;
      end
      default: begin
        opa = '0;
      end
    endcase
    sum = opa + opb + {{(sglu_pkg::SUM_W-1){1'b0}}, cin};
  end

  assign gcd_done = (st.x == '0) || (st.y == '0);
  assign gcd_val  = ((st.x == '0) ? st.y : st.x) << st.k;

  // next working state
  always_comb begin
    nx    = st;
    ovf_n = st.ovf | (sum[sglu_pkg::SUM_W-1:sglu_pkg::DATA_W-1] != '0);
    case (op)
      sglu_pkg::ALU_GCD: begin
        if (gcd_done) begin
          nx = st;
        end else if (!st.x[0] && !st.y[0]) begin
          nx.x = st.x >> 1;
          nx.y = st.y >> 1;
          nx.k = st.k + 1'b1;
        end else if (!st.x[0]) begin
          nx.x = st.x >> 1;
        end else if (!st.y[0]) begin
          nx.y = st.y >> 1;
        end else if (x_ge_y) begin
          // both odd: difference is even, halve it right away
          nx.x = sum[sglu_pkg::DATA_W:1];
        end else begin
          nx.y = sum[sglu_pkg::DATA_W:1];
        end
      end
      sglu_pkg::ALU_DIV: begin
        nx.rem = sum[sglu_pkg::SUM_W-1] ? rem_sh[sglu_pkg::DATA_W-1:0]
                                        : sum[sglu_pkg::DATA_W-1:0];
        nx.quo = {st.quo[sglu_pkg::DATA_W-2:0], ~sum[sglu_pkg::SUM_W-1]};
      end
      sglu_pkg::ALU_MUL: begin
        // sticky overflow once the partial product passes int64 max
        nx.ovf = ovf_n;
        nx.acc = ovf_n ? st.acc : sum[sglu_pkg::DATA_W-1:0];
        nx.quo = {st.quo[sglu_pkg::DATA_W-2:0], 1'b0};
      end
      default: begin
        nx = st;
      end
    endcase
  end

endmodule

// ----- hw/rtl/sglu_seq.sv -----
// ----------------------------------------------------------------------------
// sglu_seq
// Sequencer: loads magnitudes, runs gcd (plus divide and multiply for an lcm)
// on the shared step unit and holds the finished result until it is handed over.
// ----------------------------------------------------------------------------
`include "signed_gcd_lcm_unit_assert.svh"

module sglu_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             kind,
  input  logic [sglu_pkg::DATA_W-1:0]      opnd_a,
  input  logic [sglu_pkg::DATA_W-1:0]      opnd_b,
  input  logic                             res_take,
  output sglu_pkg::seq_stat_t              stat,
  output sglu_pkg::res_t                   res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

  state_t                           state_r, state_nxt;
  logic                             kind_r, kind_nxt;
  logic [sglu_pkg::DATA_W-1:0]      ma_r, ma_nxt;
  logic [sglu_pkg::DATA_W-1:0]      mb_r, mb_nxt;
  logic [sglu_pkg::DATA_W-1:0]      g_r, g_nxt;
  logic [sglu_pkg::STEP_W-1:0]      cnt_r, cnt_nxt;
  sglu_pkg::work_t                  w_r, w_nxt;
  sglu_pkg::res_t                   res_r, res_nxt;

  sglu_pkg::alu_op_t                alu_op;
  logic [sglu_pkg::DATA_W-1:0]      alu_den;
  sglu_pkg::work_t                  alu_nx;
  logic                             gcd_done;
  logic [sglu_pkg::DATA_W-1:0]      gcd_val;
  logic [sglu_pkg::DATA_W-1:0]      mag_a;
  logic [sglu_pkg::DATA_W-1:0]      mag_b;

  // magnitude as unsigned: the most negative value maps to 2^63
  assign mag_a = opnd_a[sglu_pkg::DATA_W-1] ? (~opnd_a + 1'b1) : opnd_a;
  assign mag_b = opnd_b[sglu_pkg::DATA_W-1] ? (~opnd_b + 1'b1) : opnd_b;

  sglu_alu u_alu (
    .op       (alu_op),
    .st       (w_r),
    .den      (alu_den),
    .nx       (alu_nx),
    .gcd_done (gcd_done),
    .gcd_val  (gcd_val)
  );

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    g_nxt     = g_r;
    cnt_nxt   = cnt_r;
    w_nxt     = w_r;
    res_nxt   = res_r;
    alu_op    = sglu_pkg::ALU_GCD;
    alu_den   = g_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt = kind;
          ma_nxt   = mag_a;
          mb_nxt   = mag_b;
          w_nxt.x  = mag_a;
          w_nxt.y  = mag_b;
          w_nxt.k  = '0;
          if (kind == sglu_pkg::KIND_LCM && (mag_a == '0 || mag_b == '0)) begin
            res_nxt.value = '0;
            res_nxt.ovf   = 1'b0;
            state_nxt     = ST_FIN;
          end else begin
            state_nxt = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        alu_op = sglu_pkg::ALU_GCD;
        w_nxt  = alu_nx;
        if (gcd_done) begin
          g_nxt = gcd_val;
          if (kind_r == sglu_pkg::KIND_GCD) begin
            res_nxt.value = gcd_val;
            res_nxt.ovf   = gcd_val[sglu_pkg::DATA_W-1];
            state_nxt     = ST_FIN;
          end else begin
            w_nxt.rem = '0;
            w_nxt.quo = ma_r;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        alu_op  = sglu_pkg::ALU_DIV;
        alu_den = g_r;
        w_nxt   = alu_nx;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == sglu_pkg::LAST_STEP) begin
          w_nxt.acc = '0;
          w_nxt.ovf = 1'b0;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        alu_op  = sglu_pkg::ALU_MUL;
        alu_den = mb_r;
        w_nxt   = alu_nx;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == sglu_pkg::LAST_STEP) begin
          res_nxt.value = alu_nx.ovf ? '1 : alu_nx.acc;
          res_nxt.ovf   = alu_nx.ovf;
          state_nxt     = ST_FIN;
        end
      end
      ST_FIN: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    kind_r <= kind_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    g_r    <= g_nxt;
    cnt_r  <= cnt_nxt;
    w_r    <= w_nxt;
    res_r  <= res_nxt;
  end

  assign stat.idle = (state_r == ST_IDLE);
  assign stat.done = (state_r == ST_FIN);
  assign res       = res_r;

  `SGLU_CHECK(a_rem_below_den, (state_r != ST_DIV) || (w_r.rem < g_r), "remainder not below divisor")
  `SGLU_CHECK(a_acc_in_range, (state_r != ST_MUL) || !w_r.acc[sglu_pkg::DATA_W-1], "partial product above int64 max")
  `SGLU_CHECK_NEXT(a_start_leaves_idle, start && (state_r == ST_IDLE), state_r != ST_IDLE, "start did not leave idle")
  `SGLU_CHECK_NEXT(a_res_held, (state_r == ST_FIN) && !res_take, (state_r == ST_FIN) && $stable(res_r), "result dropped before handover")

endmodule

// ----- hw/rtl/signed_gcd_lcm_unit.sv -----
// ----------------------------------------------------------------------------
// signed_gcd_lcm_unit
// Greatest common divisor or least common multiple of two signed 64-bit words.
// ----------------------------------------------------------------------------
// One request word in, one result word out. The unit works on one request at
// a time: in_ready is high only while the sequencer is idle, and a finished
// result sits in an output register so the next request can be taken while
// the result waits for out_ready. All arithmetic runs on one shared 66-bit
// adder, one step per cycle. Each request is loaded, then runs a binary gcd
// (one shift or subtract-and-halve per cycle, data dependent), and the result
// is then handed to the output register. An lcm adds a restoring divide
// (|a| / gcd) and a shift-add multiply with overflow detection. An lcm with
// a zero operand skips the gcd, divide and multiply phases and yields zero.
// ----------------------------------------------------------------------------
module signed_gcd_lcm_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic signed [sglu_pkg::DATA_W-1:0] in_operand_a,
  input  logic signed [sglu_pkg::DATA_W-1:0] in_operand_b,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [sglu_pkg::DATA_W-1:0] out_result_value,
  output logic                               out_overflow
);

  sglu_pkg::seq_stat_t         stat;
  sglu_pkg::res_t              res;
  logic                        start;
  logic                        res_take;
  logic                        out_valid_r;
  logic [sglu_pkg::DATA_W-1:0] out_value_r;
  logic                        out_ovf_r;

  // a request word is taken only while the sequencer is idle
  assign in_ready = stat.idle;
  assign start    = in_valid & stat.idle;

  // move the finished word into the output register when it is free or
  // being drained in the same cycle
  assign res_take = stat.done & (~out_valid_r | out_ready);

  sglu_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .kind     (in_kind),
    .opnd_a   ($unsigned(in_operand_a)),
    .opnd_b   ($unsigned(in_operand_b)),
    .res_take (res_take),
    .stat     (stat),
    .res      (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_value_r <= res.value;
      out_ovf_r   <= res.ovf;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(out_value_r);
  assign out_overflow     = out_ovf_r;

endmodule
